// ===== design/sef_pkg.sv =====
package sef_pkg;

  localparam int unsigned PortW = 32;
  localparam int unsigned MaskW = 32;

  // Runner-up value of one side, with its position mask.
  typedef struct packed {
    logic                    valid;
    logic signed [PortW-1:0] value;
    logic        [MaskW-1:0] mask;
  } sef_runner_t;

endpackage

// ===== design/sef_if.sv =====
interface sef_in_if import sef_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PortW-1:0] value;
  logic                    last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface sef_out_if import sef_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    has_second;
  logic signed [PortW-1:0] second_largest;
  logic        [MaskW-1:0] second_largest_positions;
  logic signed [PortW-1:0] second_smallest;
  logic        [MaskW-1:0] second_smallest_positions;
  logic                    overflow;

  modport source (output valid, has_second, second_largest, second_largest_positions,
                  second_smallest, second_smallest_positions, overflow, input ready);
  modport sink   (input valid, has_second, second_largest, second_largest_positions,
                  second_smallest, second_smallest_positions, overflow, output ready);
endinterface

// ===== design/sef_extreme.sv =====
module sef_extreme import sef_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    first_i,
  input  logic signed [PortW-1:0] value_i,
  input  logic        [MaskW-1:0] bit_i,
  output sef_runner_t             runner_o
);

  logic signed [PortW-1:0] top_q, top_d;
  logic        [MaskW-1:0] top_mask_q, top_mask_d;
  sef_runner_t             ru_q, ru_d;

  always_comb begin
    top_d      = top_q;
    top_mask_d = top_mask_q;
    ru_d       = ru_q;
    if (first_i) begin
      top_d      = value_i;
      top_mask_d = bit_i;
      ru_d       = '0;
    end else if (value_i > top_q) begin
      ru_d       = '{valid: 1'b1, value: top_q, mask: top_mask_q};
      top_d      = value_i;
      top_mask_d = bit_i;
    end else if (value_i == top_q) begin
      top_mask_d = top_mask_q | bit_i;
    end else if (!ru_q.valid || value_i > ru_q.value) begin
      ru_d = '{valid: 1'b1, value: value_i, mask: bit_i};
    end else if (value_i == ru_q.value) begin
      ru_d.mask = ru_q.mask | bit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q      <= '0;
      top_mask_q <= '0;
      ru_q       <= '0;
    end else if (en_i) begin
      top_q      <= top_d;
      top_mask_q <= top_mask_d;
      ru_q       <= ru_d;
    end
  end

  assign runner_o = ru_d;

endmodule

// ===== design/second_extreme_finder.sv =====
// Second largest / second smallest distinct value of a list.
// in_i: one list element per beat (value, last). The low min(DATA_WIDTH, 32)
//   bits of value are used, sign-extended. last marks the final element.
// out_o: one beat per list, issued for the element carrying last: both
//   runner-up values with their position masks, has_second (list held two
//   or more distinct values; fields are zero otherwise) and overflow (list
//   longer than MAX_ITEMS; later elements still compare but mark no bit).
// Throughput: one element per cycle, unless a last element is held by a
// stalled out_o (see Stall below). The last element passes through the input
// register, then the result register, which drives out_o; it can wait in the
// input register while out_o stalls.
// Reset clears all list state and the valid bits of both pipeline registers;
// the first element after reset or after a result starts a new list.
// Stall: the result register holds while out_o.ready is low; non-last
// elements keep flowing, a last element waits in the input register until
// the result register frees up, and in_i.ready then drops.
module second_extreme_finder import sef_pkg::*; #(
  parameter int unsigned MAX_ITEMS  = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sef_in_if.sink    in_i,
  sef_out_if.source out_o
);

  localparam int unsigned ValW = (DATA_WIDTH < PortW) ? DATA_WIDTH : PortW;
  localparam int unsigned IdxW = $clog2(MAX_ITEMS + 1);

  logic                    s1_valid_q;
  logic signed [PortW-1:0] s1_value_q;
  logic                    s1_last_q;
  logic                    s1_go;
  logic                    in_take;
  logic signed [ValW-1:0]  in_narrow;

  logic [IdxW-1:0]         idx_q;
  logic                    too_long_q, too_long_d;
  logic                    pos_ok;
  logic [MaskW-1:0]        pos_bit;
  logic                    first;

  sef_runner_t             hi_ru, lo_ru;
  logic                    has;

  logic                    out_valid_q;
  logic                    res_has_q;
  logic signed [PortW-1:0] res_hi_q, res_lo_q;
  logic        [MaskW-1:0] res_hi_mask_q, res_lo_mask_q;
  logic                    res_ovf_q;

  assign s1_go      = s1_valid_q & (!s1_last_q | !out_valid_q | out_o.ready);
  assign in_i.ready = !s1_valid_q | s1_go;
  assign in_take    = in_i.valid & in_i.ready;
  assign in_narrow  = in_i.value[ValW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_value_q <= PortW'(in_narrow);
      s1_last_q  <= in_i.last;
    end
  end

  // position of the element in the input register
  assign first      = (idx_q == '0);
  assign pos_ok     = (idx_q < IdxW'(MAX_ITEMS));
  assign too_long_d = too_long_q | !pos_ok;
  assign pos_bit    = (pos_ok && MaskW'(idx_q) < MaskW) ? (MaskW'(1) << idx_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      too_long_q <= 1'b0;
    end else if (s1_go) begin
      if (s1_last_q) begin
        idx_q      <= '0;
        too_long_q <= 1'b0;
      end else begin
        if (pos_ok) begin
          idx_q <= idx_q + IdxW'(1);
        end
        too_long_q <= too_long_d;
      end
    end
  end

  sef_extreme u_high (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (s1_go),
    .first_i  (first),
    .value_i  (s1_value_q),
    .bit_i    (pos_bit),
    .runner_o (hi_ru)
  );

  // bitwise inversion reverses signed order, so the low side reuses the max tracker
  sef_extreme u_low (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (s1_go),
    .first_i  (first),
    .value_i  (~s1_value_q),
    .bit_i    (pos_bit),
    .runner_o (lo_ru)
  );

  assign has = hi_ru.valid & lo_ru.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      res_has_q     <= has;
      res_hi_q      <= has ? hi_ru.value : '0;
      res_hi_mask_q <= has ? hi_ru.mask : '0;
      res_lo_q      <= has ? ~lo_ru.value : '0;
      res_lo_mask_q <= has ? lo_ru.mask : '0;
      res_ovf_q     <= too_long_d;
    end
  end

  assign out_o.valid                     = out_valid_q;
  assign out_o.has_second                = res_has_q;
  assign out_o.second_largest            = res_hi_q;
  assign out_o.second_largest_positions  = res_hi_mask_q;
  assign out_o.second_smallest           = res_lo_q;
  assign out_o.second_smallest_positions = res_lo_mask_q;
  assign out_o.overflow                  = res_ovf_q;

endmodule

// ===== tb/second_extreme_finder_tb.sv =====
`timescale 1ns / 100ps

module second_extreme_finder_tb;
  import sef_pkg::*;

  localparam int unsigned ListCap     = 32;
  localparam int unsigned ListItems   = 1300;
  localparam int unsigned IdlePct     = 34;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PlanRows    = 16;

  typedef struct packed {
    logic                    has_second;
    logic signed [PortW-1:0] second_largest;
    logic        [MaskW-1:0] second_largest_positions;
    logic signed [PortW-1:0] second_smallest;
    logic        [MaskW-1:0] second_smallest_positions;
    logic                    overflow;
  } list_result_t;

  typedef struct {
    logic signed [PortW-1:0] value;
    int unsigned             count;
    logic                    last;
    bit                      pinned;
    list_result_t            result;
  } plan_row_t;

  typedef struct {
    bit           pinned;
    list_result_t result;
  } pinned_result_t;

  localparam list_result_t NoSecond = '0;

  // value, repeat count, last on final copy, result pinned, pinned result
  plan_row_t plan [PlanRows] = '{
    '{32'sd5, 1, 1'b1, 1'b1, NoSecond},
    '{-32'sd7, 3, 1'b1, 1'b1, NoSecond},
    '{32'sh8000_0000, 1, 1'b0, 1'b0, NoSecond},
    '{32'sh7FFF_FFFF, 1, 1'b1, 1'b1,
      '{1'b1, 32'sh8000_0000, 32'h0000_0001, 32'sh7FFF_FFFF, 32'h0000_0002, 1'b0}},
    '{32'sd4, 31, 1'b0, 1'b0, NoSecond},
    '{-32'sd4, 1, 1'b1, 1'b1,
      '{1'b1, -32'sd4, 32'h8000_0000, 32'sd4, 32'h7FFF_FFFF, 1'b0}},
    '{32'sd10, 32, 1'b0, 1'b0, NoSecond},
    '{32'sd20, 1, 1'b1, 1'b1,
      '{1'b1, 32'sd10, 32'hFFFF_FFFF, 32'sd20, 32'h0000_0000, 1'b1}},
    '{32'sd3, 1, 1'b0, 1'b0, NoSecond},
    '{32'sd5, 1, 1'b0, 1'b0, NoSecond},
    '{32'sd9, 1, 1'b0, 1'b0, NoSecond},
    '{-32'sd1, 2, 1'b0, 1'b0, NoSecond},
    '{32'sd5, 1, 1'b0, 1'b0, NoSecond},
    '{32'sd0, 1, 1'b1, 1'b0, NoSecond},
    '{32'sh8000_0000, 2, 1'b0, 1'b0, NoSecond},
    '{32'sh7FFF_FFFF, 2, 1'b1, 1'b0, NoSecond}
  };

  logic clk_i;
  logic rst_ni;

  sef_in_if  in_if ();
  sef_out_if out_if ();

  second_extreme_finder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  list_result_t   expected_results[$];
  pinned_result_t pinned_results[$];
  int unsigned    mismatches;
  int unsigned    results_seen;
  int unsigned    items_sent;
  int unsigned    cycle_count;

  // running list state
  int unsigned             elem_pos;
  logic signed [PortW-1:0] top_val, top_runner, bottom_val, bottom_runner;
  logic        [MaskW-1:0] top_mask, top_runner_mask, bottom_mask, bottom_runner_mask;
  logic                    top_runner_ok, bottom_runner_ok, list_overflow;

  function automatic void clear_list();
    elem_pos           = 0;
    top_val            = '0;
    top_mask           = '0;
    top_runner         = '0;
    top_runner_mask    = '0;
    top_runner_ok      = 1'b0;
    bottom_val         = '0;
    bottom_mask        = '0;
    bottom_runner      = '0;
    bottom_runner_mask = '0;
    bottom_runner_ok   = 1'b0;
    list_overflow      = 1'b0;
  endfunction

  function automatic void fold_element(input logic signed [PortW-1:0] v, input logic is_last);
    logic [MaskW-1:0] bit_at;
    list_result_t     r;
    bit_at = '0;
    if (elem_pos >= ListCap) list_overflow = 1'b1;
    else bit_at = MaskW'(1) << elem_pos;

    if (elem_pos == 0) begin
      clear_list();
      top_val     = v;
      top_mask    = bit_at;
      bottom_val  = v;
      bottom_mask = bit_at;
    end else begin
      if (v > top_val) begin
        top_runner      = top_val;
        top_runner_mask = top_mask;
        top_runner_ok   = 1'b1;
        top_val         = v;
        top_mask        = bit_at;
      end else if (v == top_val) begin
        top_mask |= bit_at;
      end else if (!top_runner_ok || v > top_runner) begin
        top_runner      = v;
        top_runner_mask = bit_at;
        top_runner_ok   = 1'b1;
      end else if (v == top_runner) begin
        top_runner_mask |= bit_at;
      end

      if (v < bottom_val) begin
        bottom_runner      = bottom_val;
        bottom_runner_mask = bottom_mask;
        bottom_runner_ok   = 1'b1;
        bottom_val         = v;
        bottom_mask        = bit_at;
      end else if (v == bottom_val) begin
        bottom_mask |= bit_at;
      end else if (!bottom_runner_ok || v < bottom_runner) begin
        bottom_runner      = v;
        bottom_runner_mask = bit_at;
        bottom_runner_ok   = 1'b1;
      end else if (v == bottom_runner) begin
        bottom_runner_mask |= bit_at;
      end
    end

    if (elem_pos < ListCap) elem_pos++;

    if (is_last) begin
      r = '0;
      r.has_second = top_runner_ok && bottom_runner_ok;
      if (r.has_second) begin
        r.second_largest            = top_runner;
        r.second_largest_positions  = top_runner_mask;
        r.second_smallest           = bottom_runner;
        r.second_smallest_positions = bottom_runner_mask;
      end
      r.overflow = list_overflow;
      expected_results.push_back(r);
      clear_list();
    end
  endfunction

  function automatic void flag_mismatch(input string what, input logic [PortW-1:0] want,
                                        input logic [PortW-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endfunction

  function automatic logic signed [PortW-1:0] pick_value(input int unsigned flavor);
    logic signed [PortW-1:0] corner [7];
    corner = '{32'sh8000_0000, 32'sh8000_0001, -32'sd1, 32'sd0, 32'sd1,
               32'sh7FFF_FFFE, 32'sh7FFF_FFFF};
    case (flavor)
      0: return $urandom;
      1: return PortW'($urandom_range(6)) - 3;
      2: return corner[$urandom_range(6)];
      default: return $urandom_range(1) ? PortW'($urandom) : PortW'($urandom_range(6)) - 3;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_element(input logic signed [PortW-1:0] v, input logic is_last,
                              input bit pinned, input list_result_t pinned_val);
    int unsigned idle_pct;
    pinned_result_t slot;
    idle_pct = (items_sent >= 400 && items_sent < 700) ? 0 : IdlePct;
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    if (is_last) begin
      slot.pinned = pinned;
      slot.result = pinned_val;
      pinned_results.push_back(slot);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    in_if.last  <= is_last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[second_extreme_finder] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin : watch
    list_result_t   got, want;
    pinned_result_t slot;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        fold_element(in_if.value, in_if.last);
        if (in_if.last && pinned_results.size() != 0) begin
          slot = pinned_results.pop_front();
          if (slot.pinned) expected_results[$] = slot.result;
        end
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        got.has_second                = out_if.has_second;
        got.second_largest            = out_if.second_largest;
        got.second_largest_positions  = out_if.second_largest_positions;
        got.second_smallest           = out_if.second_smallest;
        got.second_smallest_positions = out_if.second_smallest_positions;
        got.overflow                  = out_if.overflow;
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result, second_largest", '0, got.second_largest);
        end else begin
          want = expected_results.pop_front();
          if (got.has_second !== want.has_second)
            flag_mismatch("has_second", want.has_second, got.has_second);
          if (got.second_largest !== want.second_largest)
            flag_mismatch("second_largest", want.second_largest, got.second_largest);
          if (got.second_largest_positions !== want.second_largest_positions)
            flag_mismatch("second_largest_positions", want.second_largest_positions,
                          got.second_largest_positions);
          if (got.second_smallest !== want.second_smallest)
            flag_mismatch("second_smallest", want.second_smallest, got.second_smallest);
          if (got.second_smallest_positions !== want.second_smallest_positions)
            flag_mismatch("second_smallest_positions", want.second_smallest_positions,
                          got.second_smallest_positions);
          if (got.overflow !== want.overflow)
            flag_mismatch("overflow", want.overflow, got.overflow);
        end
      end
    end
  end

  // result side: random stalls, an idle-free stretch, two long hold-offs
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned next_hold;
    hold_left    = 0;
    next_hold    = 20;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && next_hold != 0 && results_seen >= next_hold) begin
        hold_left = HoldCycles;
        next_hold = (next_hold < 100) ? 150 : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (results_seen >= 60 && results_seen < 110) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin : list_source
    int unsigned len;
    int unsigned flavor;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    in_if.last   = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    items_sent   = 0;
    cycle_count  = 0;
    clear_list();
    wait (rst_ni);
    @(negedge clk_i);

    foreach (plan[r]) begin
      for (int unsigned k = 0; k < plan[r].count; k++)
        send_element(plan[r].value, plan[r].last && (k == plan[r].count - 1),
                     plan[r].pinned, plan[r].result);
    end

    while (items_sent < ListItems) begin
      len    = ($urandom_range(14) == 0) ? $urandom_range(40, 30) : $urandom_range(8, 1);
      flavor = $urandom_range(3);
      for (int unsigned k = 0; k < len; k++)
        send_element(pick_value(flavor), k == len - 1, 1'b0, NoSecond);
    end
    in_if.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0)
      $display("[second_extreme_finder] OK");
    else
      $display("[second_extreme_finder] ERROR");
    $finish;
  end

endmodule
